[src/dram_bank_group_timing_update_assert.svh]
// ----------------------------------------------------------------------------
// dram bank group timing update assertion macros
// checks sampled on the rising clock edge, muted while reset is high
// ----------------------------------------------------------------------------
`ifndef DRAM_BANK_GROUP_TIMING_UPDATE_ASSERT_SVH
`define DRAM_BANK_GROUP_TIMING_UPDATE_ASSERT_SVH

// same-cycle implication
`define DBGTU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DBGTU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/dbgtu_pkg.sv]
// ----------------------------------------------------------------------------
// dbgtu_pkg
// shared types, widths and command codes of the bank group timing update
// ----------------------------------------------------------------------------
`default_nettype none

package dbgtu_pkg;

   localparam int NumBanks = 4;
   localparam int BankW    = 2;
   localparam int CycW     = 48;
   localparam int RegW     = 8;
   localparam int OffW     = 10;
   localparam int ModeW    = 3;
   localparam int IdxW     = 3;

   typedef logic [BankW-1:0] bank_type;
   typedef logic [CycW-1:0]  cyc_type;
   typedef logic [RegW-1:0]  reg_type;
   typedef logic [OffW-1:0]  off_type;
   typedef logic [ModeW-1:0] mode_type;
   typedef logic [IdxW-1:0]  idx_type;
   typedef logic [1:0]       kind_type;

   // command codes
   localparam mode_type ModeAct   = 3'd0;
   localparam mode_type ModeRd    = 3'd1;
   localparam mode_type ModeRdAp  = 3'd2;
   localparam mode_type ModeWr    = 3'd3;
   localparam mode_type ModeWrAp  = 3'd4;

   // command class held during the bank sweep
   localparam kind_type KindAct = 2'd0;
   localparam kind_type KindRd  = 2'd1;
   localparam kind_type KindWr  = 2'd2;

   // register indexes
   localparam idx_type RegActGap  = 3'd0;
   localparam idx_type RegColGap  = 3'd1;
   localparam idx_type RegBurst   = 3'd2;
   localparam idx_type RegRdLat   = 3'd3;
   localparam idx_type RegRdWrGap = 3'd4;
   localparam idx_type RegWrLat   = 3'd5;
   localparam idx_type RegWrRdGap = 3'd6;

   typedef struct packed {
      logic     en;
      kind_type kind;
      bank_type idx;
   } upd_type;

endpackage

`default_nettype wire

[src/dbgtu_satadd.sv]
// ----------------------------------------------------------------------------
// dbgtu_satadd
// shared saturating adder: cycle plus a short offset, clamped at the cycle max
// ----------------------------------------------------------------------------
`default_nettype none

module dbgtu_satadd (
   input  wire dbgtu_pkg::cyc_type base,
   input  wire dbgtu_pkg::off_type offset,
   output dbgtu_pkg::cyc_type      sum
);
   import dbgtu_pkg::*;

   logic [CycW:0] wide;

   always_comb begin
      wide = {1'b0, base} + {{(CycW+1-OffW){1'b0}}, offset};
      sum  = wide[CycW] ? {CycW{1'b1}} : wide[CycW-1:0];
   end

endmodule

`default_nettype wire

[src/dbgtu_limits.sv]
// ----------------------------------------------------------------------------
// dbgtu_limits
// per-bank activate, read and write limits with running-maximum update
// ----------------------------------------------------------------------------
`default_nettype none

module dbgtu_limits (
   input  wire                     clock,
   input  wire                     reset,
   input  wire dbgtu_pkg::upd_type upd,
   input  wire dbgtu_pkg::cyc_type tgt0,
   input  wire dbgtu_pkg::cyc_type tgt1,
   output dbgtu_pkg::cyc_type      new_act,
   output dbgtu_pkg::cyc_type      new_rd,
   output dbgtu_pkg::cyc_type      new_wr
);
   import dbgtu_pkg::*;

   cyc_type act_ff [NumBanks];
   cyc_type rd_ff  [NumBanks];
   cyc_type wr_ff  [NumBanks];

   cyc_type old_act;
   cyc_type old_rd;
   cyc_type old_wr;
   logic    is_act;

   always_comb begin
      old_act = act_ff[upd.idx];
      old_rd  = rd_ff[upd.idx];
      old_wr  = wr_ff[upd.idx];
      is_act  = (upd.kind == KindAct);
      new_act = (is_act && tgt0 > old_act) ? tgt0 : old_act;
      new_rd  = (!is_act && tgt0 > old_rd) ? tgt0 : old_rd;
      new_wr  = (!is_act && tgt1 > old_wr) ? tgt1 : old_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumBanks; i++) begin
            act_ff[i] <= '0;
            rd_ff[i]  <= '0;
            wr_ff[i]  <= '0;
         end
      end else if (upd.en) begin
         act_ff[upd.idx] <= new_act;
         rd_ff[upd.idx]  <= new_rd;
         wr_ff[upd.idx]  <= new_wr;
      end
   end

endmodule

`default_nettype wire

[src/dram_bank_group_timing_update.sv]
// ----------------------------------------------------------------------------
// dram_bank_group_timing_update
// the target sums are formed in StAdd0 and StAdd1 by the shared saturating adder,
// then the sweep visits one bank slot per cycle while the result beat is not
// stalled, skipping the command's own bank; each result beat is registered.
// A new command is taken only in StIdle, once the sweep of the last one has ended.
// reset: synchronous, limits cleared to zero and registers to their defaults
// ----------------------------------------------------------------------------
`default_nettype none
`include "dram_bank_group_timing_update_assert.svh"

module dram_bank_group_timing_update (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_wr_en,
   input  wire dbgtu_pkg::idx_type   csr_index,
   input  wire dbgtu_pkg::reg_type   csr_wdata,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire dbgtu_pkg::mode_type  req_mode,
   input  wire dbgtu_pkg::bank_type  req_bank,
   input  wire dbgtu_pkg::cyc_type   req_cycle,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output dbgtu_pkg::bank_type       rsp_target_bank,
   output dbgtu_pkg::cyc_type        rsp_next_activate,
   output dbgtu_pkg::cyc_type        rsp_next_read,
   output dbgtu_pkg::cyc_type        rsp_next_write,
   output logic                      rsp_last
);
   import dbgtu_pkg::*;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StAdd0 = 2'd1;
   localparam logic [1:0] StAdd1 = 2'd2;
   localparam logic [1:0] StBank = 2'd3;

   // configuration
   reg_type act_gap_ff, col_gap_ff, burst_ff, rd_lat_ff, rd_wr_gap_ff, wr_lat_ff, wr_rd_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_gap_ff   <= 8'd6;
         col_gap_ff   <= 8'd6;
         burst_ff     <= 8'd4;
         rd_lat_ff    <= 8'd16;
         rd_wr_gap_ff <= 8'd2;
         wr_lat_ff    <= 8'd12;
         wr_rd_gap_ff <= 8'd9;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            RegActGap:  act_gap_ff   <= csr_wdata;
            RegColGap:  col_gap_ff   <= csr_wdata;
            RegBurst:   burst_ff     <= csr_wdata;
            RegRdLat:   rd_lat_ff    <= csr_wdata;
            RegRdWrGap: rd_wr_gap_ff <= csr_wdata;
            RegWrLat:   wr_lat_ff    <= csr_wdata;
            RegWrRdGap: wr_rd_gap_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // offsets from the configuration
   reg_type col_off;
   off_type rd_sum;
   off_type rw_off;
   off_type wr_sum;

   always_comb begin
      col_off = (col_gap_ff > burst_ff) ? col_gap_ff : burst_ff;
      rd_sum  = {2'b00, rd_lat_ff} + {2'b00, burst_ff} + {2'b00, rd_wr_gap_ff};
      rw_off  = (rd_sum > {2'b00, wr_lat_ff}) ? rd_sum - {2'b00, wr_lat_ff} : '0;
      wr_sum  = {2'b00, wr_lat_ff} + {2'b00, burst_ff} + {2'b00, wr_rd_gap_ff};
   end

   // sequencer state
   logic [1:0] state_ff, state_in;
   bank_type   bank_ff, bank_in;
   bank_type   idx_ff, idx_in;
   kind_type   kind_ff, kind_in;
   cyc_type    cycle_ff, cycle_in;
   off_type    off0_ff, off0_in;
   off_type    off1_ff, off1_in;
   cyc_type    tgt0_ff, tgt0_in;
   cyc_type    tgt1_ff, tgt1_in;

   logic       req_take;
   logic       cmd_ok;
   kind_type   cmd_kind;
   off_type    cmd_off0;
   off_type    cmd_off1;
   bank_type   last_idx;
   logic       out_free;
   logic       out_load;
   cyc_type    add_sum;
   upd_type    upd;
   cyc_type    new_act, new_rd, new_wr;

   assign req_stall = (state_ff != StIdle);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cmd_ok   = (NumBanks > 1) && (int'(req_bank) < NumBanks);
      cmd_kind = KindAct;
      cmd_off0 = {2'b00, act_gap_ff};
      cmd_off1 = '0;
      unique case (req_mode)
         ModeAct: begin
            cmd_kind = KindAct;
            cmd_off0 = {2'b00, act_gap_ff};
         end
         ModeRd, ModeRdAp: begin
            cmd_kind = KindRd;
            cmd_off0 = {2'b00, col_off};
            cmd_off1 = rw_off;
         end
         ModeWr, ModeWrAp: begin
            cmd_kind = KindWr;
            cmd_off0 = wr_sum;
            cmd_off1 = {2'b00, col_off};
         end
         default: begin
            cmd_ok = 1'b0;
         end
      endcase
   end

   dbgtu_satadd u_satadd (
      .base   (cycle_ff),
      .offset ((state_ff == StAdd1) ? off1_ff : off0_ff),
      .sum    (add_sum)
   );

   assign last_idx = (int'(bank_ff) == NumBanks - 1) ? BankW'(NumBanks - 2)
                                                     : BankW'(NumBanks - 1);
   assign out_free = !rsp_valid || !rsp_stall;
   assign out_load = (state_ff == StBank) && (idx_ff != bank_ff) && out_free;

   always_comb begin
      upd.en   = out_load;
      upd.kind = kind_ff;
      upd.idx  = idx_ff;
   end

   dbgtu_limits u_limits (
      .clock   (clock),
      .reset   (reset),
      .upd     (upd),
      .tgt0    (tgt0_ff),
      .tgt1    (tgt1_ff),
      .new_act (new_act),
      .new_rd  (new_rd),
      .new_wr  (new_wr)
   );

   always_comb begin
      state_in = state_ff;
      bank_in  = bank_ff;
      idx_in   = idx_ff;
      kind_in  = kind_ff;
      cycle_in = cycle_ff;
      off0_in  = off0_ff;
      off1_in  = off1_ff;
      tgt0_in  = tgt0_ff;
      tgt1_in  = tgt1_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_take && cmd_ok) begin
               state_in = StAdd0;
               bank_in  = req_bank;
               kind_in  = cmd_kind;
               cycle_in = req_cycle;
               off0_in  = cmd_off0;
               off1_in  = cmd_off1;
            end
         end
         StAdd0: begin
            tgt0_in  = add_sum;
            state_in = StAdd1;
         end
         StAdd1: begin
            tgt1_in  = add_sum;
            idx_in   = '0;
            state_in = StBank;
         end
         StBank: begin
            if (idx_ff == bank_ff) begin
               idx_in = idx_ff + 1'b1;
            end else if (out_free) begin
               if (idx_ff == last_idx) begin
                  state_in = StIdle;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff  <= bank_in;
      idx_ff   <= idx_in;
      kind_ff  <= kind_in;
      cycle_ff <= cycle_in;
      off0_ff  <= off0_in;
      off1_ff  <= off1_in;
      tgt0_ff  <= tgt0_in;
      tgt1_ff  <= tgt1_in;
   end

   // result beat register
   logic    rsp_valid_ff, rsp_valid_in;
   bank_type rsp_bank_ff;
   cyc_type rsp_act_ff, rsp_rd_ff, rsp_wr_ff;
   logic    rsp_last_ff;

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_bank_ff <= idx_ff;
         rsp_act_ff  <= new_act;
         rsp_rd_ff   <= new_rd;
         rsp_wr_ff   <= new_wr;
         rsp_last_ff <= (idx_ff == last_idx);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_target_bank   = rsp_bank_ff;
   assign rsp_next_activate = rsp_act_ff;
   assign rsp_next_read     = rsp_rd_ff;
   assign rsp_next_write    = rsp_wr_ff;
   assign rsp_last          = rsp_last_ff;

   `DBGTU_ASSERT_NOW(a_load_in_sweep, out_load, state_ff == StBank && idx_ff != bank_ff,
      "result beat loaded outside the bank sweep")
   `DBGTU_ASSERT_NEXT(a_last_ends_sweep, out_load && idx_ff == last_idx, state_ff == StIdle,
      "sweep did not end after its last beat")
   `DBGTU_ASSERT_NEXT(a_cmd_starts_sums, req_take && cmd_ok, state_ff == StAdd0 && req_stall,
      "accepted command did not start the target sums")

endmodule

`default_nettype wire
